[hw/rtl/ivs_pkg.sv]
// ivs_pkg: word types, address constants and palettes shared by the
// byte-cell scanout modules. No dependencies.
`default_nettype none

package ivs_pkg;

    localparam int unsigned ADDR_W = 14;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam logic [ADDR_W-1:0] COLOUR_BASE       = 14'h2800;
    localparam logic [ADDR_W-1:0] STRIP_PIXEL_BASE  = 14'h2000;
    localparam logic [ADDR_W-1:0] STRIP_COLOUR_BASE = 14'h0800;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [5:0]        column;
        logic [7:0]        line;
        logic              blink_phase_on;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_0;
        logic [31:0] pixel_1;
        logic [31:0] pixel_2;
        logic [31:0] pixel_3;
        logic [31:0] pixel_4;
        logic [31:0] pixel_5;
        logic [31:0] pixel_6;
        logic [31:0] pixel_7;
    } result_t;

    // pattern and attribute read addresses of one cell
    typedef struct packed {
        logic [ADDR_W-1:0] pix;
        logic [ADDR_W-1:0] attr;
    } cell_addr_t;

    function automatic logic [31:0] fore_colour(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0:    c = 32'hFF000000;
            4'd1:    c = 32'hFFFF0000;
            4'd2:    c = 32'hFF0000FF;
            4'd3:    c = 32'hFFFF00FF;
            4'd4:    c = 32'hFF00FF00;
            4'd5:    c = 32'hFFFFFF00;
            4'd6:    c = 32'hFF00FFFF;
            4'd7:    c = 32'hFFFFFFFF;
            4'd8:    c = 32'hFF000000;
            4'd9:    c = 32'hFFFF00A0;
            4'd10:   c = 32'hFF00A0FF;
            4'd11:   c = 32'hFFA000FF;
            4'd12:   c = 32'hFFA0FF00;
            4'd13:   c = 32'hFFFFA000;
            4'd14:   c = 32'hFF00FFA0;
            default: c = 32'hFFFFFFFF;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] back_colour(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'hFF000000;
            3'd1:    c = 32'hFFA00000;
            3'd2:    c = 32'hFF0000A0;
            3'd3:    c = 32'hFFA000A0;
            3'd4:    c = 32'hFF00A000;
            3'd5:    c = 32'hFFA0A000;
            3'd6:    c = 32'hFF00A0A0;
            default: c = 32'hFFA0A0A0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ivs_ram.sv]
// ivs_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
`default_nettype none

module ivs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ivs_addr_gen.sv]
// ivs_addr_gen: interleaved pattern and attribute addresses of a byte cell.
// Depends on ivs_pkg.
`default_nettype none

module ivs_addr_gen (
    input  wire logic [5:0]         column,
    input  wire logic [7:0]         line,
    output ivs_pkg::cell_addr_t     addr
);
    import ivs_pkg::*;

    logic [ADDR_W-1:0] left_pix;
    logic [ADDR_W-1:0] left_attr;
    logic [ADDR_W-1:0] strip_pix;
    logic [ADDR_W-1:0] strip_attr;

    always_comb
    begin
        // left quad: columns 0..31
        left_pix  = {1'b0, line[7:4], line[1:0], line[3:2], column[4:0]};
        left_attr = COLOUR_BASE | {3'b000, line[7:2], column[4:0]};
        // right strip: low three column bits only, so 40..63 wrap onto 32..39
        strip_pix  = STRIP_PIXEL_BASE
                   | {3'b000, line[7:6], line[1:0], line[3:2], line[5:4], column[2:0]};
        // both bases share bit 11, so they add rather than merge
        strip_attr = COLOUR_BASE + STRIP_COLOUR_BASE
                   + {5'b00000, line[7:6], line[3:2], line[5:4], column[2:0]};
        if (column[5])
        begin
            addr.pix  = strip_pix;
            addr.attr = strip_attr;
        end
        else
        begin
            addr.pix  = left_pix;
            addr.attr = left_attr;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ivs_shade.sv]
// ivs_shade: palette lookup, blink masking and expansion of one pattern
// byte into eight ABGR pixels. Depends on ivs_pkg.
`default_nettype none

module ivs_shade (
    input  wire logic [7:0]     pattern,
    input  wire logic [7:0]     attr,
    input  wire logic           blink_phase_on,
    output ivs_pkg::result_t    pixels
);
    import ivs_pkg::*;

    logic [31:0] bg;
    logic [31:0] fg;
    logic [31:0] fg_shown;

    always_comb
    begin
        bg = back_colour(attr[2:0]);
        fg = fore_colour(attr[6:3]);
        // blinking cell in the off phase shows background only
        fg_shown = (!blink_phase_on && attr[7]) ? bg : fg;
        pixels.pixel_0 = pattern[7] ? fg_shown : bg;
        pixels.pixel_1 = pattern[6] ? fg_shown : bg;
        pixels.pixel_2 = pattern[5] ? fg_shown : bg;
        pixels.pixel_3 = pattern[4] ? fg_shown : bg;
        pixels.pixel_4 = pattern[3] ? fg_shown : bg;
        pixels.pixel_5 = pattern[2] ? fg_shown : bg;
        pixels.pixel_6 = pattern[1] ? fg_shown : bg;
        pixels.pixel_7 = pattern[0] ? fg_shown : bg;
    end

endmodule

`default_nettype wire

[hw/rtl/interleaved_video_scanout_top.sv]
// interleaved_video_scanout_top: video store and byte-cell scanout.
// Depends on ivs_pkg, ivs_ram, ivs_addr_gen, ivs_shade.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------
//   item     | item_valid    | item_stall    | item   (ivs_pkg::item_t)
//   result   | result_valid  | result_stall  | result (ivs_pkg::result_t)
//
// One word per cycle on the item side while item_stall is low. A write
// to an address below VIDEO_BYTES lands in the store at the accepting edge;
// a render reads both bytes from the dual-read store; its result is registered.
// A render word's result never shows a write accepted in an earlier cycle
// as stale: the store read happens at a later edge than the write.
// Reset clears only control; store contents are undefined until written.
// result_stall backs up through the read stage into item_stall.
`default_nettype none

module interleaved_video_scanout_top #(
    parameter int VIDEO_BYTES = 16384
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire ivs_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ivs_pkg::result_t      result
);
    import ivs_pkg::*;

    localparam int RAM_AW = $clog2(VIDEO_BYTES);
    localparam logic [ADDR_W:0] STORE_LIMIT = (ADDR_W+1)'(VIDEO_BYTES);

    logic       item_take;
    logic       wr_en;
    logic       rd_en;
    logic       s1_adv;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_blink_reg;
    logic       result_valid_reg;
    logic       result_valid_next;
    result_t    result_reg;
    cell_addr_t cell_addr;
    logic [7:0] pattern;
    logic [7:0] attr;
    result_t    pixels;

    ivs_addr_gen u_addr_gen (
        .column (item.column),
        .line   (item.line),
        .addr   (cell_addr)
    );

    ivs_ram #(
        .WIDTH (8),
        .DEPTH (VIDEO_BYTES)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (RAM_AW'(item.write_address)),
        .wr_data   (item.write_data),
        .rd_en     (rd_en),
        .rd_addr_a (RAM_AW'(cell_addr.pix)),
        .rd_addr_b (RAM_AW'(cell_addr.attr)),
        .rd_data_a (pattern),
        .rd_data_b (attr)
    );

    ivs_shade u_shade (
        .pattern        (pattern),
        .attr           (attr),
        .blink_phase_on (s1_blink_reg),
        .pixels         (pixels)
    );

    always_comb
    begin
        s1_adv     = s1_valid_reg && (!result_valid_reg || !result_stall);
        // read data register must hold while a render waits in the read stage
        item_stall = s1_valid_reg && !s1_adv;
        item_take  = item_valid && !item_stall;
        wr_en      = item_take && (item.action == ACT_WRITE)
                   && ({1'b0, item.write_address} < STORE_LIMIT);
        rd_en      = item_take && (item.action == ACT_RENDER);

        s1_valid_next = rd_en || (s1_valid_reg && !s1_adv);
        if (s1_adv)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_blink_reg <= item.blink_phase_on;
        end
        if (s1_adv)
        begin
            result_reg <= pixels;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_render_reaches_read_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_valid_reg
    ) else $error("accepted render did not reach the read stage");

    a_read_stage_to_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv |=> result_valid
    ) else $error("read stage advanced without a result");

    a_stall_only_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid && result_stall)
    ) else $error("item side stalled without a blocked result");

    a_no_write_during_render: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en)
    ) else $error("store written and read by one word");

endmodule

`default_nettype wire
